@@ rtl/shared_resource_lock_fifo_assert.svh @@
// Assertion macros shared by the lock FIFO RTL.
// Depends on nothing; included by the top level.
`ifndef SHARED_RESOURCE_LOCK_FIFO_ASSERT_SVH
`define SHARED_RESOURCE_LOCK_FIFO_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRLF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRLF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/srlf_pkg.sv @@
// Package for the shared resource lock FIFO: widths, modes, controller types.
// Used by every module of the block; depends on nothing.
package srlf_pkg;

    localparam int REQUESTERS_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int ID_W            = 3;
    localparam int MODE_W          = 2;
    localparam int COUNT_OUT_W     = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_SUSPEND = 2'd2,
        MODE_RESUME  = 2'd3
    } t_mode;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

endpackage

@@ rtl/srlf_ctrl.sv @@
// Controller for the lock FIFO: accepts a word, schedules execution, owns output valid.
// Depends on srlf_pkg.
module srlf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output srlf_pkg::t_cmd    o_cmd
);

    srlf_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srlf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && i_out_stall;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        o_in_stall    = 1'b1;
        unique case (r_state)
            srlf_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = srlf_pkg::ST_EXEC;
                end
            end
            srlf_pkg::ST_EXEC: begin
                if (w_out_free) begin
                    o_cmd.execute = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = srlf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = srlf_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/srlf_datapath.sv @@
// Datapath for the lock FIFO: owner, suspend flag, wait queue memory, result register.
// Depends on srlf_pkg; driven by srlf_ctrl commands.
module srlf_datapath #(
    parameter int REQUESTERS  = srlf_pkg::REQUESTERS_DEF,
    parameter int QUEUE_DEPTH = srlf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  srlf_pkg::t_cmd                    i_cmd,
    input  logic [srlf_pkg::MODE_W-1:0]       i_mode,
    input  logic [srlf_pkg::ID_W-1:0]         i_requester_id,
    output logic                              o_blocked,
    output logic                              o_error,
    output logic                              o_overflow,
    output logic                              o_owner_valid,
    output logic [srlf_pkg::ID_W-1:0]         o_owner_id,
    output logic                              o_handed_over,
    output logic                              o_is_suspended,
    output logic [srlf_pkg::COUNT_OUT_W-1:0]  o_waiting_count
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    logic [srlf_pkg::ID_W-1:0] r_mem [QUEUE_DEPTH];
    logic [srlf_pkg::ID_W-1:0] r_rd_data;

    logic [srlf_pkg::MODE_W-1:0] r_mode;
    logic [srlf_pkg::ID_W-1:0]   r_id;

    logic                      r_has_owner, n_has_owner;
    logic [srlf_pkg::ID_W-1:0] r_owner, n_owner;
    logic                      r_suspended, n_suspended;
    logic [PW-1:0]             r_head, n_head;
    logic [PW-1:0]             r_tail, n_tail;
    logic [CW-1:0]             r_count, n_count;

    logic                      w_blocked, w_error, w_overflow, w_handed, w_wr_en, w_id_ok;
    logic                      w_wait, w_handoff;
    logic [CW+srlf_pkg::COUNT_OUT_W-1:0] w_count_ext;

    logic                              r_blocked, r_error, r_overflow, r_owner_valid;
    logic [srlf_pkg::ID_W-1:0]         r_owner_id;
    logic                              r_handed_over, r_is_suspended;
    logic [srlf_pkg::COUNT_OUT_W-1:0]  r_waiting_count;

    assign w_id_ok = 32'(r_id) < 32'(REQUESTERS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode    <= i_mode;
            r_id      <= i_requester_id;
            r_rd_data <= r_mem[r_head];
        end
        if (i_cmd.execute && w_wr_en) begin
            r_mem[r_tail] <= r_id;
        end
    end

    always_comb begin
        n_has_owner = r_has_owner;
        n_owner     = r_owner;
        n_suspended = r_suspended;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        w_blocked   = 1'b0;
        w_error     = 1'b0;
        w_overflow  = 1'b0;
        w_handed    = 1'b0;
        w_wr_en     = 1'b0;
        w_handoff   = 1'b0;
        w_wait      = r_suspended || (r_has_owner && (r_owner != r_id));
        if (w_id_ok) begin
            case (srlf_pkg::t_mode'(r_mode))
                srlf_pkg::MODE_ALLOC: begin
                    if (!w_wait) begin
                        if (!r_has_owner) begin
                            n_has_owner = 1'b1;
                            n_owner     = r_id;
                        end
                    end else if (r_count == FULL_COUNT) begin
                        w_overflow = 1'b1;
                        w_error    = 1'b1;
                    end else begin
                        w_wr_en   = 1'b1;
                        n_tail    = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
                        n_count   = r_count + 1'b1;
                        w_blocked = 1'b1;
                    end
                end
                srlf_pkg::MODE_RELEASE: begin
                    w_handoff = 1'b1;
                end
                srlf_pkg::MODE_SUSPEND: begin
                    w_error     = !(r_has_owner && (r_owner == r_id));
                    n_suspended = 1'b1;
                end
                default: begin
                    if (r_suspended) begin
                        w_handoff = 1'b1;
                    end else begin
                        w_error = 1'b1;
                    end
                end
            endcase
        end
        if (w_handoff) begin
            n_suspended = 1'b0;
            if (r_count != '0) begin
                n_owner     = r_rd_data;
                n_has_owner = 1'b1;
                n_head      = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
                n_count     = r_count - 1'b1;
                w_handed    = 1'b1;
            end else begin
                n_has_owner = 1'b0;
                n_owner     = '0;
            end
        end
    end

    assign w_count_ext = {{srlf_pkg::COUNT_OUT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_owner <= 1'b0;
            r_owner     <= '0;
            r_suspended <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
        end else if (i_cmd.execute) begin
            r_has_owner <= n_has_owner;
            r_owner     <= n_owner;
            r_suspended <= n_suspended;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_blocked       <= w_blocked;
            r_error         <= w_error;
            r_overflow      <= w_overflow;
            r_owner_valid   <= n_has_owner;
            r_owner_id      <= n_has_owner ? n_owner : '0;
            r_handed_over   <= w_handed;
            r_is_suspended  <= n_suspended;
            r_waiting_count <= w_count_ext[srlf_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign o_blocked       = r_blocked;
    assign o_error         = r_error;
    assign o_overflow      = r_overflow;
    assign o_owner_valid   = r_owner_valid;
    assign o_owner_id      = r_owner_id;
    assign o_handed_over   = r_handed_over;
    assign o_is_suspended  = r_is_suspended;
    assign o_waiting_count = r_waiting_count;

endmodule

@@ rtl/shared_resource_lock_fifo.sv @@
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_mode, i_requester_id
// output    out        o_out_valid / i_out_stall  o_blocked .. o_waiting_count
//
// Each word is first captured, which registers it and issues the registered read of the
// wait queue head, then executed, which updates the lock state and loads the result register.
// A result waiting under i_out_stall holds execution of the next word in the execute state.
// Synchronous active-low reset clears owner, suspend flag and queue pointers at once.
// Top level of the shared resource lock FIFO; depends on srlf_pkg, srlf_ctrl, srlf_datapath.
`include "shared_resource_lock_fifo_assert.svh"

module shared_resource_lock_fifo #(
    parameter int REQUESTERS  = srlf_pkg::REQUESTERS_DEF,
    parameter int QUEUE_DEPTH = srlf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [srlf_pkg::MODE_W-1:0]       i_mode,
    input  logic [srlf_pkg::ID_W-1:0]         i_requester_id,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_blocked,
    output logic                              o_error,
    output logic                              o_overflow,
    output logic                              o_owner_valid,
    output logic [srlf_pkg::ID_W-1:0]         o_owner_id,
    output logic                              o_handed_over,
    output logic                              o_is_suspended,
    output logic [srlf_pkg::COUNT_OUT_W-1:0]  o_waiting_count
);

    srlf_pkg::t_cmd w_cmd;

    srlf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    srlf_datapath #(
        .REQUESTERS  (REQUESTERS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_mode          (i_mode),
        .i_requester_id  (i_requester_id),
        .o_blocked       (o_blocked),
        .o_error         (o_error),
        .o_overflow      (o_overflow),
        .o_owner_valid   (o_owner_valid),
        .o_owner_id      (o_owner_id),
        .o_handed_over   (o_handed_over),
        .o_is_suspended  (o_is_suspended),
        .o_waiting_count (o_waiting_count)
    );

    `SRLF_ASSERT_NEXT(a_busy_after_capture, i_clk, i_rst_n, w_cmd.capture, o_in_stall, "input not stalled after capture")
    `SRLF_ASSERT_NEXT(a_valid_after_exec, i_clk, i_rst_n, w_cmd.execute, o_out_valid, "no result after execution")
    `SRLF_ASSERT_NOW(a_overflow_is_error, i_clk, i_rst_n, o_out_valid && o_overflow, o_error && !o_blocked, "overflow without error")
    `SRLF_ASSERT_NOW(a_handover_owner, i_clk, i_rst_n, o_out_valid && o_handed_over, o_owner_valid && !o_is_suspended, "handover without owner")

endmodule
